// ===== design/memory_region_profiler_macros.svh =====
// ----------------------------------------------------------------------------
// Memory region profiler assertion macros
// Clocked assertion helpers shared by the profiler RTL.
// ----------------------------------------------------------------------------
`ifndef MEMORY_REGION_PROFILER_MACROS_SVH
`define MEMORY_REGION_PROFILER_MACROS_SVH

// checked only outside reset
`define MRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define MRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Memory region profiler package
// Sizes, codes and the page labeling function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrp_pkg;

  localparam int ADDR_BITS  = 15;
  localparam int MAX_PAGES  = 64;
  localparam int PAGE_BITS  = $clog2(MAX_PAGES);
  localparam int COUNT_BITS = 16;
  localparam int NUM_CNT    = 5;
  localparam int LEN_BITS   = ADDR_BITS + 1;
  localparam int SHIFT_BITS = 4;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MIN = 4'd9;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = 4'd14;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_EXEC  = 3'd2,
    OP_TRANS = 3'd3,
    OP_DUMP  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CNT_EXEC  = 3'd0,
    CNT_STACK = 3'd1,
    CNT_IO    = 3'd2,
    CNT_READ  = 3'd3,
    CNT_WRITE = 3'd4
  } cnt_e;

  typedef enum logic [2:0] {
    LBL_CODE        = 3'd0,
    LBL_CODE_RODATA = 3'd1,
    LBL_DATA        = 3'd2,
    LBL_RODATA      = 3'd3,
    LBL_STACK       = 3'd4,
    LBL_IO          = 3'd5,
    LBL_UNDECIDED   = 3'd6
  } label_e;

  typedef logic [NUM_CNT-1:0][COUNT_BITS-1:0] cnt_word_t;

  function automatic label_e page_label(input cnt_word_t w);
    logic ex, st, io, rd, wr;
    label_e l;
    ex = |w[CNT_EXEC];
    st = |w[CNT_STACK];
    io = |w[CNT_IO];
    rd = |w[CNT_READ];
    wr = |w[CNT_WRITE];
    if (ex) begin
      if (wr || st || io) l = LBL_UNDECIDED;
      else l = rd ? LBL_CODE_RODATA : LBL_CODE;
    end else if (st) begin
      l = io ? LBL_UNDECIDED : LBL_STACK;
    end else if (io) begin
      l = LBL_IO;
    end else if (wr) begin
      l = rd ? LBL_DATA : LBL_UNDECIDED;
    end else begin
      l = LBL_RODATA;
    end
    return l;
  endfunction

endpackage

// ===== design/mrp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/memory_region_profiler.sv =====
// ----------------------------------------------------------------------------
// Memory region profiler
// Per-page access counters, byte shadow memory and region dump.
// ----------------------------------------------------------------------------
// channel   dir  handshake                  contents
// s_axis    in   tvalid/tready              tuser opcode, tdata event fields
// m_axis    out  tvalid/tready              tdata region, tuser/tlast flags
// apb       in   psel/penable/pwrite        page_shift at byte address 0
//
// A data access does a shadow RAM read and compare per byte, then one shadow
// write per byte, then a counter read-modify-write for its read or write
// count, one more when io is bumped, and a last step to finish. A block event
// does a counter read-modify-write per valid bump. A dump visits each page,
// labels the touched pages, closes, and sends each region on m_axis, holding
// it while m_axis stalls. After reset all 32768 shadow valid bits are cleared;
// no request is taken meanwhile. Input is not ready while an item is in work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "memory_region_profiler_macros.svh"

module memory_region_profiler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [14:0] address, [29:15] end_address, [93:30] data_value,
  // [97:94] access_size, [112:98] stack_pointer, [113] stack_known
  input  logic [119:0] s_axis_tdata,
  // [2:0] opcode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [14:0] region_start, [30:15] region_length, [33:31] region_label
  output logic [39:0]  m_axis_tdata,
  // [0] no_regions
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AB = mrp_pkg::ADDR_BITS;
  localparam int PB = mrp_pkg::PAGE_BITS;
  localparam int CB = mrp_pkg::COUNT_BITS;
  localparam int LB = mrp_pkg::LEN_BITS;
  localparam int SB = mrp_pkg::SHIFT_BITS;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CLEAR = 10'b0000000010,
    ST_RD    = 10'b0000000100,
    ST_CMP   = 10'b0000001000,
    ST_WR    = 10'b0000010000,
    ST_CRD   = 10'b0000100000,
    ST_CWR   = 10'b0001000000,
    ST_DRD   = 10'b0010000000,
    ST_DLBL  = 10'b0100000000,
    ST_DOUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [SB-1:0] page_shift_q, page_shift_d;
  logic [SB-1:0] sh;

  logic [AB-1:0] addr_q, addr_d;
  logic [63:0]   data_q, data_d;
  logic [3:0]    size_q, size_d;
  logic [2:0]    idx_q, idx_d;
  logic          wr_q, wr_d, allv_q, allv_d, same_q, same_d;
  logic [AB-1:0] clr_q, clr_d;

  logic [PB-1:0]       bpg_q [2];
  logic [PB-1:0]       bpg_d [2];
  mrp_pkg::cnt_e       bsel_q [2];
  mrp_pkg::cnt_e       bsel_d [2];
  logic [1:0]          bv_q, bv_d;
  logic                cur_q, cur_d;
  logic [mrp_pkg::MAX_PAGES-1:0] touched_q, touched_d;

  logic [PB:0]    pidx_q, pidx_d;
  logic [PB-1:0]  first_q, first_d, last_q, last_d;
  mrp_pkg::label_e cur_lbl_q, cur_lbl_d, lbl;
  logic           have_q, have_d, final_q, final_d;

  logic [AB-1:0]  o_start_q, o_start_d;
  logic [LB-1:0]  o_len_q, o_len_d;
  logic [2:0]     o_lbl_q, o_lbl_d;
  logic           o_none_q, o_none_d, o_last_q, o_last_d, o_valid_q, o_valid_d;

  logic              sh_we;
  logic [AB-1:0]     sh_waddr, sh_raddr;
  logic [8:0]        sh_wdata, sh_rdata;
  logic              ct_we;
  logic [PB-1:0]     ct_waddr, ct_raddr;
  mrp_pkg::cnt_word_t ct_wdata, ct_rdata, ct_word;

  logic [AB-1:0] in_addr, in_end, in_sp, pg_a, pg_e, pg_s;
  logic [63:0]   in_data;
  logic [3:0]    in_size;
  logic          in_known, pg_a_ok, pg_e_ok, pg_s_ok, size_ok, cfg_wr;
  logic [AB:0]   in_top;
  logic [7:0]    dbyte;
  logic          idx_last;
  logic [LB-1:0] emit_start, emit_len;
  logic [PB:0]   emit_pages;

  assign in_addr  = s_axis_tdata[14:0];
  assign in_end   = s_axis_tdata[29:15];
  assign in_data  = s_axis_tdata[93:30];
  assign in_size  = s_axis_tdata[97:94];
  assign in_sp    = s_axis_tdata[112:98];
  assign in_known = s_axis_tdata[113];

  assign sh = (page_shift_q < mrp_pkg::SHIFT_MIN) ? mrp_pkg::SHIFT_MIN :
              (page_shift_q > mrp_pkg::SHIFT_MAX) ? mrp_pkg::SHIFT_MAX : page_shift_q;

  assign pg_a    = in_addr >> sh;
  assign pg_e    = in_end >> sh;
  assign pg_s    = in_sp >> sh;
  assign pg_a_ok = pg_a < AB'(mrp_pkg::MAX_PAGES);
  assign pg_e_ok = pg_e < AB'(mrp_pkg::MAX_PAGES);
  assign pg_s_ok = pg_s < AB'(mrp_pkg::MAX_PAGES);
  assign in_top  = {1'b0, in_addr} + (AB+1)'(in_size);
  assign size_ok = (in_size != 4'd0) && (in_size <= 4'd8) &&
                   (in_top <= (AB+1)'(1 << AB));

  assign dbyte    = data_q[{idx_q, 3'b000} +: 8];
  assign idx_last = ({1'b0, idx_q} == (size_q - 4'd1));

  assign emit_pages = {1'b0, last_q} - {1'b0, first_q} + (PB+1)'(1);
  assign emit_start = LB'(first_q) << sh;
  assign emit_len   = LB'(emit_pages) << sh;

  assign ct_word = touched_q[bpg_q[cur_q]] ? ct_rdata : '0;
  assign lbl     = mrp_pkg::page_label(ct_rdata);

  // configuration
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'b0, page_shift_q} : 32'b0;
  assign page_shift_d = cfg_wr ? pwdata[SB-1:0] : page_shift_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {6'b0, o_lbl_q, o_len_q, o_start_q};
  assign m_axis_tuser  = o_none_q;
  assign m_axis_tlast  = o_last_q;

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    data_d    = data_q;
    size_d    = size_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    allv_d    = allv_q;
    same_d    = same_q;
    clr_d     = clr_q;
    bpg_d     = bpg_q;
    bsel_d    = bsel_q;
    bv_d      = bv_q;
    cur_d     = cur_q;
    touched_d = touched_q;
    pidx_d    = pidx_q;
    first_d   = first_q;
    last_d    = last_q;
    cur_lbl_d = cur_lbl_q;
    have_d    = have_q;
    final_d   = final_q;
    o_start_d = o_start_q;
    o_len_d   = o_len_q;
    o_lbl_d   = o_lbl_q;
    o_none_d  = o_none_q;
    o_last_d  = o_last_q;
    o_valid_d = o_valid_q;
    sh_we     = 1'b0;
    sh_waddr  = addr_q + AB'(idx_q);
    sh_wdata  = {1'b1, dbyte};
    sh_raddr  = addr_q + AB'(idx_q);
    ct_we     = 1'b0;
    ct_waddr  = bpg_q[cur_q];
    ct_wdata  = ct_word;
    ct_raddr  = bpg_q[cur_q];

    unique case (state_q)
      ST_CLEAR: begin
        sh_we    = 1'b1;
        sh_waddr = clr_q;
        sh_wdata = '0;
        clr_d    = clr_q + AB'(1);
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          addr_d = in_addr;
          data_d = in_data;
          size_d = in_size;
          idx_d  = '0;
          allv_d = 1'b1;
          same_d = 1'b1;
          case (mrp_pkg::op_e'(s_axis_tuser))
            mrp_pkg::OP_READ, mrp_pkg::OP_WRITE: begin
              wr_d     = (s_axis_tuser == mrp_pkg::OP_WRITE);
              bpg_d[0] = pg_a[PB-1:0];
              bpg_d[1] = pg_a[PB-1:0];
              if (size_ok && pg_a_ok) state_d = ST_RD;
            end
            mrp_pkg::OP_EXEC: begin
              bpg_d[0]  = pg_a[PB-1:0];
              bsel_d[0] = mrp_pkg::CNT_EXEC;
              bv_d[0]   = pg_a_ok;
              bpg_d[1]  = pg_s[PB-1:0];
              bsel_d[1] = mrp_pkg::CNT_STACK;
              bv_d[1]   = in_known && pg_s_ok;
              state_d   = ST_CRD;
            end
            mrp_pkg::OP_TRANS: begin
              bpg_d[0]  = pg_a[PB-1:0];
              bsel_d[0] = mrp_pkg::CNT_EXEC;
              bv_d[0]   = pg_a_ok;
              bpg_d[1]  = pg_e[PB-1:0];
              bsel_d[1] = mrp_pkg::CNT_EXEC;
              bv_d[1]   = pg_e_ok;
              state_d   = ST_CRD;
            end
            mrp_pkg::OP_DUMP: begin
              pidx_d  = '0;
              have_d  = 1'b0;
              state_d = ST_DRD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!sh_rdata[8]) allv_d = 1'b0;
        else if (sh_rdata[7:0] != dbyte) same_d = 1'b0;
        if (idx_last) begin
          idx_d   = '0;
          state_d = ST_WR;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = ST_RD;
        end
      end
      ST_WR: begin
        sh_we = 1'b1;
        if (idx_last) begin
          bv_d[0]   = 1'b1;
          bv_d[1]   = !wr_q && allv_q && !same_q;
          bsel_d[0] = wr_q ? mrp_pkg::CNT_WRITE : mrp_pkg::CNT_READ;
          bsel_d[1] = mrp_pkg::CNT_IO;
          state_d   = ST_CRD;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_CRD: begin
        cur_d    = !bv_q[0];
        ct_raddr = bpg_q[!bv_q[0]];
        state_d  = (bv_q == 2'b00) ? ST_IDLE : ST_CWR;
      end
      ST_CWR: begin
        ct_we = 1'b1;
        if (ct_word[bsel_q[cur_q]] != {CB{1'b1}}) begin
          ct_wdata[bsel_q[cur_q]] = ct_word[bsel_q[cur_q]] + CB'(1);
        end
        touched_d[bpg_q[cur_q]] = 1'b1;
        bv_d[cur_q] = 1'b0;
        state_d = ST_CRD;
      end
      ST_DRD: begin
        ct_raddr = pidx_q[PB-1:0];
        if (pidx_q[PB]) begin
          o_valid_d = 1'b1;
          o_last_d  = 1'b1;
          o_none_d  = !have_q;
          o_start_d = have_q ? emit_start[AB-1:0] : '0;
          o_len_d   = have_q ? emit_len : '0;
          o_lbl_d   = have_q ? cur_lbl_q : '0;
          final_d   = 1'b1;
          state_d   = ST_DOUT;
        end else if (!touched_q[pidx_q[PB-1:0]]) begin
          pidx_d = pidx_q + (PB+1)'(1);
        end else begin
          state_d = ST_DLBL;
        end
      end
      ST_DLBL: begin
        pidx_d = pidx_q + (PB+1)'(1);
        if (have_q && (pidx_q == {1'b0, last_q} + (PB+1)'(1)) && (lbl == cur_lbl_q)) begin
          last_d  = pidx_q[PB-1:0];
          state_d = ST_DRD;
        end else begin
          if (have_q) begin
            o_valid_d = 1'b1;
            o_last_d  = 1'b0;
            o_none_d  = 1'b0;
            o_start_d = emit_start[AB-1:0];
            o_len_d   = emit_len;
            o_lbl_d   = cur_lbl_q;
            final_d   = 1'b0;
            state_d   = ST_DOUT;
          end else begin
            state_d = ST_DRD;
          end
          first_d   = pidx_q[PB-1:0];
          last_d    = pidx_q[PB-1:0];
          cur_lbl_d = lbl;
          have_d    = 1'b1;
        end
      end
      ST_DOUT: begin
        if (m_axis_tready) begin
          o_valid_d = 1'b0;
          state_d   = final_q ? ST_IDLE : ST_DRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      page_shift_q <= mrp_pkg::SHIFT_MIN;
      clr_q        <= '0;
      bv_q         <= '0;
      cur_q        <= 1'b0;
      touched_q    <= '0;
      o_valid_q    <= 1'b0;
      have_q       <= 1'b0;
      final_q      <= 1'b0;
      pidx_q       <= '0;
    end else begin
      state_q      <= state_d;
      page_shift_q <= page_shift_d;
      clr_q        <= clr_d;
      bv_q         <= bv_d;
      cur_q        <= cur_d;
      touched_q    <= touched_d;
      o_valid_q    <= o_valid_d;
      have_q       <= have_d;
      final_q      <= final_d;
      pidx_q       <= pidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    data_q    <= data_d;
    size_q    <= size_d;
    idx_q     <= idx_d;
    wr_q      <= wr_d;
    allv_q    <= allv_d;
    same_q    <= same_d;
    bpg_q     <= bpg_d;
    bsel_q    <= bsel_d;
    first_q   <= first_d;
    last_q    <= last_d;
    cur_lbl_q <= cur_lbl_d;
    o_start_q <= o_start_d;
    o_len_q   <= o_len_d;
    o_lbl_q   <= o_lbl_d;
    o_none_q  <= o_none_d;
    o_last_q  <= o_last_d;
  end

  mrp_ram #(
    .WIDTH (9),
    .DEPTH (1 << AB)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_waddr),
    .wdata_i (sh_wdata),
    .raddr_i (sh_raddr),
    .rdata_o (sh_rdata)
  );

  mrp_ram #(
    .WIDTH (mrp_pkg::NUM_CNT * CB),
    .DEPTH (mrp_pkg::MAX_PAGES)
  ) u_counters (
    .clk_i   (clk_i),
    .we_i    (ct_we),
    .waddr_i (ct_waddr),
    .wdata_i (ct_wdata),
    .raddr_i (ct_raddr),
    .rdata_o (ct_rdata)
  );

  `MRP_ASSERT(a_no_in_while_out, s_axis_tready |-> !m_axis_tvalid, "input ready with result pending")
  `MRP_ASSERT(a_empty_dump, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)), "bad empty dump")
  `MRP_ASSERT(a_clear_writes_invalid, (state_q == ST_CLEAR) |-> (sh_we && !sh_wdata[8]), "clear pass wrote valid byte")
  `MRP_ASSERT(a_bump_touches, (state_q == ST_CWR) |=> touched_q[$past(bpg_q[cur_q])], "counted page not marked touched")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Memory region profiler testbench
// Drives trace events and dumps over the stream input, changes page_shift
// over APB between phases, and checks every dumped region against a
// behavioral model of the per-page counters and byte shadow kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mrp_pkg::*;

  localparam int MEM_SIZE  = 1 << ADDR_BITS;
  localparam int WATCHDOG  = 200000;
  localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  memory_region_profiler dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [14:0] start;
    logic [15:0] length;
    logic [2:0]  label;
    logic        empty;
    logic        last;
  } region_t;

  logic [7:0]            shadow_mem   [MEM_SIZE];
  logic                  shadow_ok    [MEM_SIZE];
  logic                  touched      [MAX_PAGES];
  logic [COUNT_BITS-1:0] exec_cnt     [MAX_PAGES];
  logic [COUNT_BITS-1:0] stack_cnt    [MAX_PAGES];
  logic [COUNT_BITS-1:0] io_cnt       [MAX_PAGES];
  logic [COUNT_BITS-1:0] rd_cnt       [MAX_PAGES];
  logic [COUNT_BITS-1:0] wr_cnt       [MAX_PAGES];
  logic [3:0]            shift_reg;

  region_t region_q[$];
  int      errors = 0;
  int      idle_cycles = 0;

  function automatic int cur_shift();
    if (shift_reg < SHIFT_MIN) return SHIFT_MIN;
    if (shift_reg > SHIFT_MAX) return SHIFT_MAX;
    return shift_reg;
  endfunction

  task automatic bump(input int kind, input int pg);
    if (pg >= MAX_PAGES) return;
    touched[pg] = 1'b1;
    case (kind)
      CNT_EXEC:  if (exec_cnt[pg]  != CNT_TOP) exec_cnt[pg]++;
      CNT_STACK: if (stack_cnt[pg] != CNT_TOP) stack_cnt[pg]++;
      CNT_IO:    if (io_cnt[pg]    != CNT_TOP) io_cnt[pg]++;
      CNT_READ:  if (rd_cnt[pg]    != CNT_TOP) rd_cnt[pg]++;
      default:   if (wr_cnt[pg]    != CNT_TOP) wr_cnt[pg]++;
    endcase
  endtask

  function automatic label_e label_of(input int p);
    bit ex, st, io, rd, wr;
    ex = exec_cnt[p] != 0; st = stack_cnt[p] != 0; io = io_cnt[p] != 0;
    rd = rd_cnt[p] != 0;   wr = wr_cnt[p] != 0;
    if (ex) return (wr || st || io) ? LBL_UNDECIDED : (rd ? LBL_CODE_RODATA : LBL_CODE);
    if (st) return io ? LBL_UNDECIDED : LBL_STACK;
    if (io) return LBL_IO;
    if (wr) return rd ? LBL_DATA : LBL_UNDECIDED;
    return LBL_RODATA;
  endfunction

  task automatic push_region(input int first, input int last, input label_e lbl);
    region_t r;
    int sh;
    sh = cur_shift();
    r.start  = 15'((first << sh) & (MEM_SIZE - 1));
    r.length = 16'(((last - first + 1) << sh) & (2 * MEM_SIZE - 1));
    r.label  = lbl;
    r.empty  = 1'b0;
    r.last   = 1'b0;
    region_q.insert(region_q.size(), r);
  endtask

  task automatic predict_regions();
    bit have;
    int first, last;
    label_e cur, l;
    region_t r;
    have = 0; first = 0; last = 0; cur = LBL_CODE;
    for (int p = 0; p < MAX_PAGES; p++) begin
      if (!touched[p]) continue;
      l = label_of(p);
      if (have && p == last + 1 && l == cur) begin
        last = p;
      end else begin
        if (have) push_region(first, last, cur);
        first = p; last = p; cur = l; have = 1;
      end
    end
    if (have) begin
      push_region(first, last, cur);
      region_q[region_q.size() - 1].last = 1'b1;
    end else begin
      r = '0;
      r.empty = 1'b1;
      r.last = 1'b1;
      region_q.insert(region_q.size(), r);
    end
  endtask

  task automatic model_access(input int a, input logic [63:0] v, input int sz, input bit wr);
    int pg;
    bit all_ok, same;
    pg = a >> cur_shift();
    if (sz < 1 || sz > 8 || a + sz > MEM_SIZE || pg >= MAX_PAGES) return;
    all_ok = 1; same = 1;
    for (int i = 0; i < sz; i++) begin
      if (!shadow_ok[a+i]) all_ok = 0;
      else if (shadow_mem[a+i] != v[8*i +: 8]) same = 0;
    end
    if (!wr && all_ok && !same) bump(CNT_IO, pg);
    for (int i = 0; i < sz; i++) begin
      shadow_mem[a+i] = v[8*i +: 8];
      shadow_ok[a+i] = 1'b1;
    end
    bump(wr ? CNT_WRITE : CNT_READ, pg);
  endtask

  task automatic model_event(input logic [2:0] op, input int a, input int ea,
                             input logic [63:0] v, input int sz, input int sp,
                             input bit spk);
    int sh;
    sh = cur_shift();
    case (op)
      OP_READ:  model_access(a, v, sz, 0);
      OP_WRITE: model_access(a, v, sz, 1);
      OP_EXEC: begin
        bump(CNT_EXEC, a >> sh);
        if (spk) bump(CNT_STACK, sp >> sh);
      end
      OP_TRANS: begin
        bump(CNT_EXEC, a >> sh);
        bump(CNT_EXEC, ea >> sh);
      end
      OP_DUMP: predict_regions();
      default: ;
    endcase
  endtask

  int burst_left = 0;

  // valid stays high after a request; a gap or drain() takes it down
  task automatic send_event(input logic [2:0] op, input logic [14:0] a, input logic [14:0] ea,
                            input logic [63:0] v, input logic [3:0] sz,
                            input logic [14:0] sp, input logic spk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, spk, sp, sz, v, ea, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    model_event(op, a, ea, v, sz, sp, spk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (region_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_shift(input logic [3:0] val);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shift_reg = val;
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 5) == 0);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    region_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.start  = m_axis_tdata[14:0];
      got.length = m_axis_tdata[30:15];
      got.label  = m_axis_tdata[33:31];
      got.empty  = m_axis_tuser;
      got.last   = m_axis_tlast;
      if (region_q.size() == 0) begin
        $display("%0t: unexpected region, expected none, actual %p", $time, got);
        errors++;
      end else begin
        exp_r = region_q.pop_front();
        if (got.start != exp_r.start) begin
          $display("%0t: region_start expected %0d actual %0d", $time, exp_r.start, got.start);
          errors++;
        end
        if (got.length != exp_r.length) begin
          $display("%0t: region_length expected %0d actual %0d", $time, exp_r.length,
                   got.length);
          errors++;
        end
        if (got.label != exp_r.label) begin
          $display("%0t: region_label expected %0d actual %0d", $time, exp_r.label, got.label);
          errors++;
        end
        if (got.empty != exp_r.empty) begin
          $display("%0t: no_regions expected %0d actual %0d", $time, exp_r.empty, got.empty);
          errors++;
        end
        if (got.last != exp_r.last) begin
          $display("%0t: last_region expected %0d actual %0d", $time, exp_r.last, got.last);
          errors++;
        end
      end
    end
  end

  // watchdog; the shadow clear after reset is covered by the limit
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** memory_region_profiler: FAILED **");
      $finish;
    end
  end

  function automatic logic [14:0] rand_addr();
    case ($urandom_range(0, 3))
      0: return 15'($urandom_range(0, 63));
      1: return 15'($urandom_range(32760, 32767));
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic test_empty_dump();
    send_event(OP_DUMP, '0, '0, '0, '0, '0, 1'b0);
    drain();
  endtask

  task automatic test_directed();
    send_event(OP_WRITE, 15'd0, '0, 64'h1122334455667788, 4'd8, '0, 1'b0);
    send_event(OP_READ, 15'd0, '0, 64'h1122334455667788, 4'd8, '0, 1'b0);
    send_event(OP_READ, 15'd0, '0, 64'hffffffffffffffff, 4'd8, '0, 1'b0);
    send_event(OP_READ, 15'd600, '0, 64'h0, 4'd0, '0, 1'b0);
    send_event(OP_READ, 15'd600, '0, 64'h0, 4'd15, '0, 1'b0);
    send_event(OP_WRITE, 15'd32767, '0, 64'hab, 4'd1, '0, 1'b0);
    send_event(OP_WRITE, 15'd32766, '0, 64'h0, 4'd4, '0, 1'b0);
    send_event(OP_EXEC, 15'd1024, '0, '0, '0, 15'd2000, 1'b1);
    send_event(OP_EXEC, 15'd1536, '0, '0, '0, 15'h7fff, 1'b0);
    send_event(OP_TRANS, 15'd3000, 15'd3100, '0, '0, '0, 1'b0);
    send_event(OP_TRANS, 15'd4000, 15'h7fff, '0, '0, '0, 1'b0);
    send_event(3'd5, 15'h7fff, 15'h7fff, '1, 4'hf, 15'h7fff, 1'b1);
    send_event(3'd6, '0, '0, '0, '0, '0, 1'b0);
    send_event(3'd7, '0, '0, '0, '0, '0, 1'b0);
    send_event(OP_READ, 15'd5000, '0, 64'h5a, 4'd1, '0, 1'b0);
    send_event(OP_DUMP, '0, '0, '0, '0, '0, 1'b0);
    drain();
  endtask

  task automatic test_saturation();
    // count width allows saturation only in long runs; hammer one page
    for (int i = 0; i < 20; i++)
      send_event(OP_TRANS, 15'd6000, 15'd6001, '0, '0, '0, 1'b0);
    send_event(OP_DUMP, '0, '0, '0, '0, '0, 1'b0);
    drain();
  endtask

  task automatic test_random(input int n);
    logic [2:0] op;
    logic [14:0] a;
    logic [3:0] sz;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: op = OP_READ;
        6, 7, 8, 9, 10:   op = OP_WRITE;
        11, 12, 13:       op = OP_EXEC;
        14, 15:           op = OP_TRANS;
        16:               op = OP_DUMP;
        17:               op = 3'($urandom_range(5, 7));
        default:          op = 3'($urandom_range(0, 7));
      endcase
      a = rand_addr();
      sz = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      // reuse a small window so reads hit shadowed bytes often
      if ((op == OP_READ || op == OP_WRITE) && $urandom_range(0, 1))
        a = 15'($urandom_range(0, 47)) + 15'(($urandom_range(0, 3)) * 4096);
      send_event(op, a, rand_addr(), {$urandom, $urandom}, sz, rand_addr(),
                 1'($urandom));
    end
    send_event(OP_DUMP, '0, '0, '0, '0, '0, 1'b0);
  endtask

  initial begin
    shift_reg = SHIFT_MIN;
    for (int i = 0; i < MEM_SIZE; i++) shadow_ok[i] = 1'b0;
    for (int p = 0; p < MAX_PAGES; p++) begin
      touched[p] = 0; exec_cnt[p] = 0; stack_cnt[p] = 0;
      io_cnt[p] = 0; rd_cnt[p] = 0; wr_cnt[p] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_dump();
    test_directed();
    test_saturation();
    write_shift(4'd14);
    test_random(100);
    write_shift(4'd0);
    test_random(100);
    write_shift(4'd15);
    test_random(100);
    write_shift(4'd11);
    test_random(100);
    write_shift(4'd9);
    test_random(100);
    drain();
    if (errors == 0 && region_q.size() == 0)
      $display("** memory_region_profiler: PASSED **");
    else
      $display("** memory_region_profiler: FAILED **");
    $finish;
  end

endmodule
